/* rtl/bsc_pkg.sv */
package bsc_pkg;

    localparam int MAX_PROCS_DEF  = 16;
    localparam int MAX_RES_DEF    = 16;
    localparam int VALUE_BITS_DEF = 16;

    localparam int CFG_BITS       = 5;
    localparam int S_DATA_BITS    = 24;
    localparam int S_USER_BITS    = 2;
    localparam int M_DATA_BITS    = 8;
    localparam int M_USER_BITS    = 1;

    localparam logic [CFG_BITS-1:0] PROC_COUNT_RST = 5'd5;
    localparam logic [CFG_BITS-1:0] RES_COUNT_RST  = 5'd3;

    typedef enum logic [1:0] {
        FUNC_LOAD_AVAIL = 2'd0,
        FUNC_LOAD_ALLOC = 2'd1,
        FUNC_LOAD_MAX   = 2'd2,
        FUNC_RUN        = 2'd3
    } func_t;

    typedef enum logic [0:0] {
        CFG_PROC_COUNT = 1'b0,
        CFG_RES_COUNT  = 1'b1
    } cfg_index_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_PROC,
        S_CHK_RD,
        S_CHK,
        S_EMIT,
        S_ADD_RD,
        S_ADD,
        S_FAIL
    } state_t;

endpackage

/* rtl/bsc_alu.sv */
module bsc_alu #(
    parameter int VALUE_BITS = bsc_pkg::VALUE_BITS_DEF
) (
    input  logic [VALUE_BITS-1:0]   max_val,
    input  logic [VALUE_BITS-1:0]   alloc_val,
    input  logic [VALUE_BITS+3:0]   work_val,
    output logic                    fits,
    output logic [VALUE_BITS+3:0]   work_sum
);
    import bsc_pkg::*;

    localparam int WW = VALUE_BITS + 4;

    logic [VALUE_BITS-1:0] need;
    logic [WW:0]           sum_full;

    always_comb
    begin
        // need clamps at zero when allocation exceeds maximum
        need     = (max_val > alloc_val) ? (max_val - alloc_val) : '0;
        fits     = (WW'(need) <= work_val);
        sum_full = {1'b0, work_val} + (WW + 1)'(alloc_val);
        work_sum = sum_full[WW] ? {WW{1'b1}} : sum_full[WW-1:0];
    end

endmodule

/* rtl/bankers_safety_check_unit.sv */
// Banker's algorithm safety checker. Load transactions (tuser 0 available,
// 1 allocation, 2 maximum) store their value and produce no output. A run
// transaction (tuser 3) walks the loaded state with one shared need/compare/
// saturating-add unit fed from the registered read port of the allocation and
// maximum memories: each pass visits every process in turn, skips finished
// ones, and for an unfinished process reads and tests one resource at a time
// up to and including the first resource that does not fit. A process whose
// resources all fit is emitted (held while the output register is still full)
// and its allocation is then read and added into work one resource at a time.
// At most process_count passes run. Output beats carry the granted process and
// its position, tlast on the final beat; tuser 0 marks failure. The input is
// not ready while a run is in progress, including cycles spent waiting for the
// output register; between runs it takes one transaction per cycle.
module bankers_safety_check_unit #(
    parameter int MAX_PROCS  = bsc_pkg::MAX_PROCS_DEF,
    parameter int MAX_RES    = bsc_pkg::MAX_RES_DEF,
    parameter int VALUE_BITS = bsc_pkg::VALUE_BITS_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [0:0]                      cfg_index,
    input  logic [bsc_pkg::CFG_BITS-1:0]    cfg_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [bsc_pkg::S_DATA_BITS-1:0] s_tdata,   // process[3:0], resource[7:4], value[23:8]
    input  logic [bsc_pkg::S_USER_BITS-1:0] s_tuser,   // func[1:0]
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [bsc_pkg::M_DATA_BITS-1:0] m_tdata,   // process_res[3:0], position[7:4]
    output logic [bsc_pkg::M_USER_BITS-1:0] m_tuser,   // safe[0]
    output logic                            m_tlast
);
    import bsc_pkg::*;

    localparam int PW    = $clog2(MAX_PROCS);
    localparam int RW    = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
    localparam int CW    = $clog2(MAX_PROCS + 1);
    localparam int RCW   = $clog2(MAX_RES + 1);
    localparam int WW    = VALUE_BITS + 4;
    localparam int AW    = PW + RW;
    localparam int DEPTH = MAX_PROCS << RW;

    state_t state_reg, state_next;

    logic [CFG_BITS-1:0]   proc_cnt_reg, res_cnt_reg;
    logic [CW-1:0]         np_reg, np_calc;
    logic [RCW-1:0]        nr_reg, nr_calc;
    logic [CW-1:0]         p_reg;
    logic [RW-1:0]         r_reg;
    logic [CW-1:0]         seq_reg;
    logic                  progress_reg;
    logic [MAX_PROCS-1:0]  finished_reg;
    logic [WW-1:0]         work_reg [0:MAX_RES-1];
    logic [VALUE_BITS-1:0] avail_reg [0:MAX_RES-1];

    logic [VALUE_BITS-1:0] alloc_mem [0:DEPTH-1];
    logic [VALUE_BITS-1:0] max_mem   [0:DEPTH-1];
    logic [VALUE_BITS-1:0] rd_alloc_reg, rd_max_reg;

    logic                  out_valid_reg, out_safe_reg, out_last_reg;
    logic [3:0]            out_proc_reg, out_pos_reg;

    logic [3:0]            in_proc, in_res;
    logic [15:0]           in_value;
    func_t                 in_func;
    logic [VALUE_BITS-1:0] in_val;
    logic                  in_accept, proc_ok, res_ok;
    logic [AW-1:0]         wr_addr, rd_addr;

    logic                  alu_fits;
    logic [WW-1:0]         alu_sum;

    logic                  pass_end, all_done, cur_finished, r_last, out_free;

    // control strobes from the sequencer
    logic                  run_start, pass_restart, p_inc, r_clr, r_inc;
    logic                  emit_grant, emit_fail, work_add;

    assign in_proc   = s_tdata[3:0];
    assign in_res    = s_tdata[7:4];
    assign in_value  = s_tdata[23:8];
    assign in_func   = func_t'(s_tuser);
    assign in_val    = VALUE_BITS'(in_value);
    assign in_accept = s_tvalid && s_tready;
    assign proc_ok   = (int'(in_proc) < MAX_PROCS);
    assign res_ok    = (int'(in_res) < MAX_RES);
    assign wr_addr   = {PW'(in_proc), RW'(in_res)};
    assign rd_addr   = {p_reg[PW-1:0], r_reg};

    assign pass_end     = (p_reg == np_reg);
    assign all_done     = (seq_reg == np_reg);
    assign cur_finished = finished_reg[p_reg[PW-1:0]];
    assign r_last       = ((RCW'(r_reg) + RCW'(1)) == nr_reg);
    assign out_free     = !out_valid_reg || m_tready;

    always_comb
    begin
        if (proc_cnt_reg == '0)
            np_calc = CW'(1);
        else if (int'(proc_cnt_reg) > MAX_PROCS)
            np_calc = CW'(MAX_PROCS);
        else
            np_calc = CW'(proc_cnt_reg);
        if (res_cnt_reg == '0)
            nr_calc = RCW'(1);
        else if (int'(res_cnt_reg) > MAX_RES)
            nr_calc = RCW'(MAX_RES);
        else
            nr_calc = RCW'(res_cnt_reg);
    end

    bsc_alu #(
        .VALUE_BITS(VALUE_BITS)
    ) u_alu (
        .max_val  (rd_max_reg),
        .alloc_val(rd_alloc_reg),
        .work_val (work_reg[r_reg]),
        .fits     (alu_fits),
        .work_sum (alu_sum)
    );

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && in_func == FUNC_RUN)
                    state_next = S_PROC;
            end
            S_PROC:
            begin
                if (pass_end)
                begin
                    if (all_done)
                        state_next = S_IDLE;
                    else if (!progress_reg)
                        state_next = S_FAIL;
                end
                else if (!cur_finished)
                    state_next = S_CHK_RD;
            end
            S_CHK_RD: state_next = S_CHK;
            S_CHK:
            begin
                if (!alu_fits)
                    state_next = S_PROC;
                else if (r_last)
                    state_next = S_EMIT;
                else
                    state_next = S_CHK_RD;
            end
            S_EMIT:
            begin
                if (out_free)
                    state_next = S_ADD_RD;
            end
            S_ADD_RD: state_next = S_ADD;
            S_ADD:
            begin
                if (r_last)
                    state_next = S_PROC;
                else
                    state_next = S_ADD_RD;
            end
            S_FAIL:
            begin
                if (out_free)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    // sequencer outputs
    always_comb
    begin
        s_tready     = 1'b0;
        run_start    = 1'b0;
        pass_restart = 1'b0;
        p_inc        = 1'b0;
        r_clr        = 1'b0;
        r_inc        = 1'b0;
        emit_grant   = 1'b0;
        emit_fail    = 1'b0;
        work_add     = 1'b0;
        case (state_reg)
            S_IDLE:
            begin
                s_tready  = 1'b1;
                run_start = s_tvalid && in_func == FUNC_RUN;
            end
            S_PROC:
            begin
                if (pass_end)
                    pass_restart = !all_done && progress_reg;
                else if (cur_finished)
                    p_inc = 1'b1;
                else
                    r_clr = 1'b1;
            end
            S_CHK:
            begin
                if (!alu_fits)
                    p_inc = 1'b1;
                else if (r_last)
                    r_clr = 1'b1;
                else
                    r_inc = 1'b1;
            end
            S_EMIT:   emit_grant = out_free;
            S_ADD:
            begin
                work_add = 1'b1;
                if (r_last)
                    p_inc = 1'b1;
                else
                    r_inc = 1'b1;
            end
            S_FAIL:   emit_fail = out_free;
            default:  s_tready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= S_IDLE;
        else
            state_reg <= state_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            proc_cnt_reg <= PROC_COUNT_RST;
            res_cnt_reg  <= RES_COUNT_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_index_t'(cfg_index))
                CFG_PROC_COUNT: proc_cnt_reg <= cfg_data;
                CFG_RES_COUNT:  res_cnt_reg  <= cfg_data;
                default:        proc_cnt_reg <= proc_cnt_reg;
            endcase
        end
    end

    // available vector: written by loads, copied into work at run start
    always_ff @(posedge clk)
    begin
        if (in_accept && in_func == FUNC_LOAD_AVAIL && res_ok)
            avail_reg[RW'(in_res)] <= in_val;
    end

    always_ff @(posedge clk)
    begin
        if (in_accept && in_func == FUNC_LOAD_ALLOC && proc_ok && res_ok)
            alloc_mem[wr_addr] <= in_val;
        if (in_accept && in_func == FUNC_LOAD_MAX && proc_ok && res_ok)
            max_mem[wr_addr] <= in_val;
        rd_alloc_reg <= alloc_mem[rd_addr];
        rd_max_reg   <= max_mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < MAX_RES; i++)
                work_reg[i] <= '0;
        end
        else if (run_start)
        begin
            for (int i = 0; i < MAX_RES; i++)
                work_reg[i] <= (i < int'(nr_calc)) ? WW'(avail_reg[i]) : '0;
        end
        else if (work_add)
            work_reg[r_reg] <= alu_sum;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            np_reg       <= CW'(1);
            nr_reg       <= RCW'(1);
            p_reg        <= '0;
            r_reg        <= '0;
            seq_reg      <= '0;
            progress_reg <= 1'b0;
            finished_reg <= '0;
        end
        else
        begin
            if (run_start)
            begin
                np_reg       <= np_calc;
                nr_reg       <= nr_calc;
                p_reg        <= '0;
                r_reg        <= '0;
                seq_reg      <= '0;
                progress_reg <= 1'b0;
                finished_reg <= '0;
            end
            if (pass_restart)
            begin
                p_reg        <= '0;
                progress_reg <= 1'b0;
            end
            if (p_inc)
                p_reg <= p_reg + CW'(1);
            if (r_clr)
                r_reg <= '0;
            if (r_inc)
                r_reg <= r_reg + RW'(1);
            if (emit_grant)
            begin
                seq_reg                     <= seq_reg + CW'(1);
                progress_reg                <= 1'b1;
                finished_reg[p_reg[PW-1:0]] <= 1'b1;
            end
        end
    end

    // output register: hold until the downstream side takes the transaction
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (emit_grant || emit_fail)
            out_valid_reg <= 1'b1;
        else if (m_tready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (emit_grant)
        begin
            out_proc_reg <= 4'(p_reg);
            out_pos_reg  <= 4'(seq_reg);
            out_safe_reg <= 1'b1;
            out_last_reg <= ((seq_reg + CW'(1)) == np_reg);
        end
        else if (emit_fail)
        begin
            out_proc_reg <= '0;
            out_pos_reg  <= 4'(seq_reg);
            out_safe_reg <= 1'b0;
            out_last_reg <= 1'b1;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out_pos_reg, out_proc_reg};
    assign m_tuser  = out_safe_reg;
    assign m_tlast  = out_last_reg;

endmodule
